// ===== src/hall_commutation_speed_gate_macros.svh =====
// Assertion macros for the hall commutation speed gate checker
`ifndef HALL_COMMUTATION_SPEED_GATE_MACROS_SVH
`define HALL_COMMUTATION_SPEED_GATE_MACROS_SVH

// same-cycle implication, reset-qualified
`define HCSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-qualified
`define HCSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hcsg_pkg.sv =====
// Shared types and constants for the hall commutation speed gate
package hcsg_pkg;

	localparam int LEVEL_W = 10;
	localparam int SUM_W   = 17;
	localparam int REG_W   = 10;
	localparam int IDX_W   = 3;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_LOW_THR  = 3'd0,
		REG_HIGH_THR = 3'd1,
		REG_RELOAD_A = 3'd2,
		REG_RELOAD_B = 3'd3,
		REG_WINDOW_A = 3'd4,
		REG_WINDOW_B = 3'd5
	} reg_idx_t;

	localparam logic [REG_W-1:0] RST_LOW_THR  = 10'd270;
	localparam logic [REG_W-1:0] RST_HIGH_THR = 10'd415;
	localparam logic [REG_W-1:0] RST_RELOAD_A = 10'd110;
	localparam logic [REG_W-1:0] RST_RELOAD_B = 10'd170;
	localparam logic [REG_W-1:0] RST_WINDOW_A = 10'd70;
	localparam logic [REG_W-1:0] RST_WINDOW_B = 10'd170;

	typedef struct packed {
		logic             opcode;
		logic [SUM_W-1:0] sum_a;
		logic [SUM_W-1:0] sum_b;
	} item_t;

	typedef struct packed {
		logic               attract_a;
		logic               repel_a;
		logic               enable_a;
		logic               attract_b;
		logic               repel_b;
		logic               enable_b;
		logic [LEVEL_W-1:0] level_a;
		logic [LEVEL_W-1:0] level_b;
	} result_t;

	typedef struct packed {
		logic [REG_W-1:0] low;
		logic [REG_W-1:0] high;
		logic [REG_W-1:0] reload;
		logic [REG_W-1:0] window;
	} chan_cfg_t;

	typedef struct packed {
		logic               attract;
		logic               repel;
		logic               enable;
		logic [LEVEL_W-1:0] level;
	} chan_state_t;

endpackage

// ===== src/hall_commutation_speed_gate.sv =====
// Top level of the two-channel hall commutation speed gate
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+---------------------------
//  item    | item_valid   | item_stall   | item   (opcode, sum_a/b)
//  result  | result_valid | result_stall | result (coils, enables, levels)
//  config  | cfg_we       | -            | cfg_idx, cfg_data
//
// One transaction per cycle sustained while the result is not stalled; a result can be
// taken once its item has passed the input register, then channel state / result register.
// Channel state doubles as the result payload and only moves when a result is loaded.
// A stalled result holds the input register; at most one more item is taken meanwhile.
// Reset returns all state and registers but the input item register to their reset values; no clearing pass.
module hall_commutation_speed_gate (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  hcsg_pkg::item_t            item,
	output logic                       result_valid,
	input  logic                       result_stall,
	output hcsg_pkg::result_t          result,
	input  logic                       cfg_we,
	input  logic [hcsg_pkg::IDX_W-1:0] cfg_idx,
	input  logic [hcsg_pkg::REG_W-1:0] cfg_data
);
	import hcsg_pkg::*;

	logic [REG_W-1:0] low_q, high_q, reload_a_q, reload_b_q, window_a_q, window_b_q;

	item_t       item_s1;
	logic        valid_s1;
	logic        adv, accept, upd;
	chan_cfg_t   cfg_a, cfg_b;
	chan_state_t st_a, st_b;

	assign adv        = !result_valid || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign upd        = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q      <= RST_LOW_THR;
			high_q     <= RST_HIGH_THR;
			reload_a_q <= RST_RELOAD_A;
			reload_b_q <= RST_RELOAD_B;
			window_a_q <= RST_WINDOW_A;
			window_b_q <= RST_WINDOW_B;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_LOW_THR:  low_q      <= cfg_data;
				REG_HIGH_THR: high_q     <= cfg_data;
				REG_RELOAD_A: reload_a_q <= cfg_data;
				REG_RELOAD_B: reload_b_q <= cfg_data;
				REG_WINDOW_A: window_a_q <= cfg_data;
				REG_WINDOW_B: window_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (upd)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
	end

	assign cfg_a = '{low: low_q, high: high_q, reload: reload_a_q, window: window_a_q};
	assign cfg_b = '{low: low_q, high: high_q, reload: reload_b_q, window: window_b_q};

	hcsg_channel u_chan_a (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.opcode (item_s1.opcode),
		.sum    (item_s1.sum_a),
		.cfg    (cfg_a),
		.st     (st_a)
	);

	hcsg_channel u_chan_b (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.opcode (item_s1.opcode),
		.sum    (item_s1.sum_b),
		.cfg    (cfg_b),
		.st     (st_b)
	);

	assign result = '{
		attract_a: st_a.attract,
		repel_a:   st_a.repel,
		enable_a:  st_a.enable,
		attract_b: st_b.attract,
		repel_b:   st_b.repel,
		enable_b:  st_b.enable,
		level_a:   st_a.level,
		level_b:   st_b.level
	};

endmodule

// ===== src/hcsg_channel.sv =====
// One motor channel: level filter, period timer, speed gate and coil drive
module hcsg_channel (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  logic                       opcode,
	input  logic [hcsg_pkg::SUM_W-1:0] sum,
	input  hcsg_pkg::chan_cfg_t        cfg,
	output hcsg_pkg::chan_state_t      st
);
	import hcsg_pkg::*;

	logic [LEVEL_W-1:0] level_q, level_d;
	logic               dir_q, dir_d;
	logic               att_q, att_d;
	logic               rep_q, rep_d;
	logic               att_prev_q, rep_prev_q;
	logic [REG_W-1:0]   timer_q, timer_d;
	logic               en_q, en_d;

	logic [SUM_W:0]      acc;
	logic [LEVEL_W-1:0]  new_level;
	logic [REG_W-1:0]    timer_ld;
	logic                en_set;
	logic signed [REG_W+1:0] margin;
	logic signed [REG_W+1:0] timer_sx;

	always_comb begin
		acc       = {{(SUM_W+1-LEVEL_W){1'b0}}, level_q} + {1'b0, sum};
		new_level = acc[SUM_W -: LEVEL_W];
		timer_ld  = (!att_prev_q && att_q) ? cfg.reload : timer_q;
		margin    = $signed({2'b00, cfg.reload}) - $signed({2'b00, cfg.window});
		timer_sx  = $signed({2'b00, timer_ld});

		level_d = level_q;
		dir_d   = dir_q;
		att_d   = att_q;
		rep_d   = rep_q;
		timer_d = timer_q;
		en_d    = en_q;
		en_set  = en_q;

		if (opcode == OP_TICK) begin
			if (timer_q != '0)
				timer_d = timer_q - 1'b1;
		end else begin
			level_d = new_level;
			timer_d = timer_ld;
			if (rep_prev_q && !rep_q) begin
				if (timer_ld == '0)
					en_set = 1'b1;
				en_d = (timer_sx > margin) ? 1'b0 : en_set;
			end
			if (cfg.low < new_level && new_level < cfg.high) begin
				att_d = dir_q;
				rep_d = !dir_q;
			end else if (new_level <= cfg.low) begin
				dir_d = (level_q <= new_level);
				att_d = 1'b0;
				rep_d = 1'b0;
			end else begin
				dir_d = 1'b0;
				att_d = 1'b0;
				rep_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			dir_q      <= 1'b0;
			att_q      <= 1'b0;
			rep_q      <= 1'b0;
			att_prev_q <= 1'b0;
			rep_prev_q <= 1'b0;
			timer_q    <= '0;
			en_q       <= 1'b0;
		end else if (upd) begin
			level_q <= level_d;
			dir_q   <= dir_d;
			att_q   <= att_d;
			rep_q   <= rep_d;
			timer_q <= timer_d;
			en_q    <= en_d;
			if (opcode == OP_STEP) begin
				att_prev_q <= att_q;
				rep_prev_q <= rep_q;
			end
		end
	end

	assign st = '{attract: att_q, repel: rep_q, enable: en_q, level: level_q};

endmodule

// ===== src/hcsg_checker.sv =====
// Port-level checker for the hall commutation speed gate, with bind
`include "hall_commutation_speed_gate_macros.svh"

module hcsg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_stall,
	input hcsg_pkg::result_t   result
);
	import hcsg_pkg::*;

	`HCSG_ASSERT_NEXT(a_valid_held, clk, arst_n, result_valid && result_stall, result_valid, "result valid dropped while stalled")
	`HCSG_ASSERT_NEXT(a_payload_held, clk, arst_n, result_valid && result_stall, $stable(result), "result payload changed while stalled")
	`HCSG_ASSERT_NOW(a_coils_excl, clk, arst_n, result_valid, !(result.attract_a && result.repel_a) && !(result.attract_b && result.repel_b), "attract and repel driven together")
	`HCSG_ASSERT_NOW(a_level_range, clk, arst_n, result_valid, result.level_a <= 10'd516 && result.level_b <= 10'd516, "filtered level out of range")

endmodule

bind hall_commutation_speed_gate hcsg_checker u_hcsg_checker (.*);

// ===== bench/hall_commutation_speed_gate_tb.sv =====
// Self-checking testbench for the two-channel hall commutation speed gate
`timescale 1ns / 1ps

module hall_commutation_speed_gate_tb;
	import hcsg_pkg::*;

	localparam int NUM_REGS = 6;
	localparam int IDLE_PCT = 38;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LEVEL_CAP = 511;
	localparam int WALK_STEP = 30;
	localparam int WALK_MARGIN = 60;
	localparam int SUM_SPEC_MAX = 130944;
	localparam int SUM_ALL_ONES = 131071;

	class drive_scoreboard;
		logic [REG_W-1:0] regs [NUM_REGS];
		logic [LEVEL_W-1:0] level [2];
		logic [REG_W-1:0] timer [2];
		bit dir [2];
		bit att_now [2];
		bit rep_now [2];
		bit att_prev [2];
		bit rep_prev [2];
		bit enable [2];
		result_t pending_drives [$];
		int mismatches;

		function new();
			regs[REG_LOW_THR] = RST_LOW_THR;
			regs[REG_HIGH_THR] = RST_HIGH_THR;
			regs[REG_RELOAD_A] = RST_RELOAD_A;
			regs[REG_RELOAD_B] = RST_RELOAD_B;
			regs[REG_WINDOW_A] = RST_WINDOW_A;
			regs[REG_WINDOW_B] = RST_WINDOW_B;
			for (int c = 0; c < 2; c++) begin
				level[c] = '0;
				timer[c] = '0;
				dir[c] = 0;
				att_now[c] = 0;
				rep_now[c] = 0;
				att_prev[c] = 0;
				rep_prev[c] = 0;
				enable[c] = 0;
			end
			mismatches = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
			if (idx < NUM_REGS)
				regs[idx] = val;
		endfunction

		function void step_channel(int c, logic [SUM_W-1:0] sum);
			logic [LEVEL_W-1:0] prior;
			logic [SUM_W:0] total;
			logic [REG_W-1:0] low;
			logic [REG_W-1:0] high;
			int reload;
			int window;
			prior = level[c];
			total = {{(SUM_W+1-LEVEL_W){1'b0}}, prior} + {1'b0, sum};
			level[c] = total[SUM_W -: LEVEL_W];
			low = regs[REG_LOW_THR];
			high = regs[REG_HIGH_THR];
			reload = int'(regs[REG_RELOAD_A + c]);
			window = int'(regs[REG_WINDOW_A + c]);
			if (!att_prev[c] && att_now[c])
				timer[c] = REG_W'(reload);
			if (rep_prev[c] && !rep_now[c]) begin
				if (timer[c] == 0 && !enable[c])
					enable[c] = 1;
				if (int'(timer[c]) > reload - window && enable[c])
					enable[c] = 0;
			end
			att_prev[c] = att_now[c];
			rep_prev[c] = rep_now[c];
			if (low < level[c] && level[c] < high) begin
				att_now[c] = dir[c];
				rep_now[c] = !dir[c];
			end else if (level[c] <= low) begin
				dir[c] = prior <= level[c];
				att_now[c] = 0;
				rep_now[c] = 0;
			end else begin
				att_now[c] = 0;
				rep_now[c] = 0;
				dir[c] = 0;
			end
		endfunction

		function void take_item(item_t it);
			result_t drive;
			if (it.opcode == OP_TICK) begin
				for (int c = 0; c < 2; c++)
					if (timer[c] != 0)
						timer[c] = timer[c] - 1'b1;
			end else begin
				step_channel(0, it.sum_a);
				step_channel(1, it.sum_b);
			end
			drive.attract_a = att_now[0];
			drive.repel_a = rep_now[0];
			drive.enable_a = enable[0];
			drive.attract_b = att_now[1];
			drive.repel_b = rep_now[1];
			drive.enable_b = enable[1];
			drive.level_a = level[0];
			drive.level_b = level[1];
			pending_drives.push_back(drive);
		endfunction

		task flag_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_drive(result_t got);
			result_t want;
			if (pending_drives.size() == 0) begin
				flag_mismatch("result with no expected drive");
				return;
			end
			want = pending_drives.pop_front();
			check_field("attract_a", 32'(got.attract_a), 32'(want.attract_a));
			check_field("repel_a", 32'(got.repel_a), 32'(want.repel_a));
			check_field("enable_a", 32'(got.enable_a), 32'(want.enable_a));
			check_field("attract_b", 32'(got.attract_b), 32'(want.attract_b));
			check_field("repel_b", 32'(got.repel_b), 32'(want.repel_b));
			check_field("enable_b", 32'(got.enable_b), 32'(want.enable_b));
			check_field("level_a", 32'(got.level_a), 32'(want.level_a));
			check_field("level_b", 32'(got.level_b), 32'(want.level_b));
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [REG_W-1:0] cfg_data = '0;

	drive_scoreboard sb;
	bit calm = 0;
	bit accepted;
	int idle_cycles = 0;

	hall_commutation_speed_gate uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			accepted = 0;
			if (item_valid && !item_stall) begin
				sb.take_item(item);
				accepted = 1;
			end
			if (result_valid && !result_stall) begin
				sb.check_drive(result);
				accepted = 1;
			end
			idle_cycles = accepted ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("hall_commutation_speed_gate_tb failed");
				$finish;
			end
		end
	end

	function automatic item_t make_item(logic op, int a, int b);
		item_t it;
		it.opcode = op;
		it.sum_a = a[SUM_W-1:0];
		it.sum_b = b[SUM_W-1:0];
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if (!calm)
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				item_valid = 1'b0;
				@(negedge clk);
			end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		item_valid = 1'b0;
		while (sb.pending_drives.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_config(input int low, input int high, input int ra, input int rb,
			input int wa, input int wb);
		write_reg(REG_LOW_THR, REG_W'(low));
		write_reg(REG_HIGH_THR, REG_W'(high));
		write_reg(REG_RELOAD_A, REG_W'(ra));
		write_reg(REG_RELOAD_B, REG_W'(rb));
		write_reg(REG_WINDOW_A, REG_W'(wa));
		write_reg(REG_WINDOW_B, REG_W'(wb));
	endtask

	// unused register slots must be ignored
	task automatic write_spare();
		write_reg(IDX_W'($urandom_range(2 ** IDX_W - 1, NUM_REGS)), REG_W'($urandom));
	endtask

	// random walk of both sensor levels around the current window, with tick bursts
	task automatic run_phase(input int count);
		int lo_b;
		int hi_b;
		int r;
		int ticks_left;
		int tgt [2];
		item_t it;
		lo_b = int'(sb.regs[REG_LOW_THR]) - WALK_MARGIN;
		hi_b = int'(sb.regs[REG_HIGH_THR]) + WALK_MARGIN;
		if (lo_b < 0)
			lo_b = 0;
		if (hi_b > LEVEL_CAP)
			hi_b = LEVEL_CAP;
		if (lo_b >= hi_b) begin
			lo_b = 0;
			hi_b = LEVEL_CAP;
		end
		tgt[0] = $urandom_range(hi_b, lo_b);
		tgt[1] = $urandom_range(hi_b, lo_b);
		ticks_left = 0;
		repeat (count) begin
			if (ticks_left > 0) begin
				it = make_item(OP_TICK, $urandom, $urandom);
				ticks_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					it = make_item(1'($urandom_range(0, 1)), $urandom, $urandom);
				end else if (r < 35) begin
					ticks_left = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 120)
						: $urandom_range(0, 5);
					it = make_item(OP_TICK, $urandom, $urandom);
				end else begin
					for (int c = 0; c < 2; c++) begin
						if ($urandom_range(0, 15) == 0)
							tgt[c] = $urandom_range(hi_b, lo_b);
						else
							tgt[c] = tgt[c] + int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP;
						if (tgt[c] < lo_b)
							tgt[c] = lo_b;
						if (tgt[c] > hi_b)
							tgt[c] = hi_b;
					end
					it = make_item(OP_STEP, (tgt[0] << 8) + $urandom_range(0, 255),
						(tgt[1] << 8) + $urandom_range(0, 255));
				end
			end
			send_item(it);
		end
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		apply_config(int'(RST_LOW_THR), int'(RST_HIGH_THR), int'(RST_RELOAD_A),
			int'(RST_RELOAD_B), int'(RST_WINDOW_A), int'(RST_WINDOW_B));
		send_item(make_item(OP_STEP, 0, 0));
		send_item(make_item(OP_TICK, SUM_ALL_ONES, SUM_ALL_ONES));
		send_item(make_item(OP_STEP, 100 << 8, SUM_SPEC_MAX));
		send_item(make_item(OP_STEP, 340 << 8, 340 << 8));
		send_item(make_item(OP_STEP, 340 << 8, 300 << 8));
		repeat (3) send_item(make_item(OP_TICK, 0, 0));
		send_item(make_item(OP_STEP, SUM_ALL_ONES, 340 << 8));
		send_item(make_item(OP_STEP, 340 << 8, 340 << 8));
		send_item(make_item(OP_STEP, 342 << 8, 342 << 8));
		send_item(make_item(OP_STEP, 0, 0));
		send_item(make_item(OP_STEP, 0, 0));
		send_item(make_item(OP_TICK, $urandom, $urandom));
		send_item(make_item(OP_STEP, 300 << 8, 500 << 8));
		send_item(make_item(OP_STEP, 350 << 8, 350 << 8));
		send_item(make_item(OP_STEP, 350 << 8, 350 << 8));
		send_item(make_item(OP_STEP, 0, SUM_ALL_ONES));
		send_item(make_item(OP_STEP, 0, 0));
		send_item(make_item(OP_STEP, SUM_SPEC_MAX, 0));
		wait_drained();

		calm = 1;
		apply_config($urandom_range(150, 300), $urandom_range(340, 480), $urandom_range(0, 40),
			$urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 40));
		run_phase(80);
		wait_drained();
		calm = 0;

		// extremes, window wider than reload on channel b
		apply_config(0, 1023, 1023, 0, 0, 1023);
		write_spare();
		run_phase(70);
		wait_drained();

		// empty threshold window
		apply_config(450, 300, $urandom_range(0, 60), $urandom_range(0, 60),
			$urandom_range(0, 60), $urandom_range(0, 60));
		run_phase(50);
		wait_drained();

		apply_config($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
		write_spare();
		run_phase(80);
		wait_drained();

		apply_config($urandom_range(100, 300), $urandom_range(320, 500), $urandom_range(0, 200),
			$urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200));
		run_phase(100);
		wait_drained();

		if (sb.pending_drives.size() != 0)
			sb.flag_mismatch($sformatf("%0d expected drives never arrived",
				sb.pending_drives.size()));
		if (sb.mismatches == 0)
			$display("hall_commutation_speed_gate_tb passed");
		else
			$display("hall_commutation_speed_gate_tb failed");
		$finish;
	end

endmodule
